/* hdl/csc_pkg.sv */
package csc_pkg;

   // store geometry
   localparam int MAX_LEN    = 64;
   localparam int MAX_LETTER = 7;
   localparam int ADDR_W     = $clog2(MAX_LEN);
   localparam int LEN_W      = $clog2(MAX_LEN + 1);
   localparam int LETTER_W   = 3;
   localparam int NUM_CODES  = 2 ** LETTER_W;

   // request command codes
   localparam logic [1:0] CMD_APPEND_PATTERN = 2'd0;
   localparam logic [1:0] CMD_APPEND_TEXT    = 2'd1;
   localparam logic [1:0] CMD_EVALUATE       = 2'd2;

   typedef struct packed {
      logic [1:0]          command;
      logic [LETTER_W-1:0] letter;
   } req_type;

   typedef struct packed {
      logic covered;
      logic overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEFT_READ,
      ST_LEFT_EXEC,
      ST_RIGHT_READ,
      ST_RIGHT_EXEC,
      ST_CHECK_READ,
      ST_CHECK_LIMIT,
      ST_SCAN,
      ST_SCAN_UPDATE,
      ST_TEST,
      ST_REPLY
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic append_pattern;
      logic append_text;
      logic start_left;
      logic left_read;
      logic left_exec;
      logic start_right;
      logic right_read;
      logic right_exec;
      logic start_check;
      logic check_read;
      logic check_limit;
      logic scan_read;
      logic scan_update;
      logic test;
      logic finish;
   } ctrl_type;

   // datapath to controller status
   typedef struct packed {
      logic idx_at_len;
      logic idx_zero;
      logic scan_more;
      logic window_hit;
   } status_type;

endpackage

/* hdl/csc_datapath.sv */
module csc_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  csc_pkg::req_type     req_data,
   input  csc_pkg::ctrl_type    ctrl,
   output csc_pkg::status_type  status,
   output csc_pkg::rsp_type     rsp_data
);

   localparam int AW = csc_pkg::ADDR_W;
   localparam int LW = csc_pkg::LEN_W;
   localparam int CW = csc_pkg::LETTER_W;

   // letter and count stores
   logic [CW-1:0] pat_mem   [csc_pkg::MAX_LEN];
   logic [CW-1:0] txt_mem   [csc_pkg::MAX_LEN];
   logic [LW-1:0] left_mem  [csc_pkg::MAX_LEN];
   logic [LW-1:0] right_mem [csc_pkg::MAX_LEN];

   logic [CW-1:0] pat_rd_ff, txt_rd_ff;
   logic [LW-1:0] left_rd_ff, right_rd_ff;

   logic [LW-1:0] pat_len_ff, txt_len_ff;
   logic          ovf_ff;
   logic [LW-1:0] idx_ff, cnt_ff, ptr_ff;
   logic          ok_ff;
   logic [csc_pkg::NUM_CODES-1:0] seen_ff;

   logic [LW-1:0] lim_ff, rcnt_ff;
   logic [CW-1:0] chr_ff;
   logic [AW-1:0] last_ff [csc_pkg::NUM_CODES];
   csc_pkg::rsp_type rsp_ff;

   logic [AW-1:0] pat_addr, txt_addr, left_addr, right_addr;
   logic [LW-1:0] idx_m1, idx_p1, pat_from_end;
   logic          match;
   logic [LW-1:0] cnt_in;
   logic [LW-1:0] l_val, r_val, lim_in;
   logic [LW:0]   l_plus, reach;
   logic          letter_ok, window_hit;
   logic          pat_full, txt_full;
   logic          rd_en;

   assign idx_m1       = idx_ff - 1'b1;
   assign idx_p1       = idx_ff + 1'b1;
   assign pat_from_end = pat_len_ff - cnt_ff - 1'b1;
   assign pat_full     = (pat_len_ff == LW'(csc_pkg::MAX_LEN));
   assign txt_full     = (txt_len_ff == LW'(csc_pkg::MAX_LEN));
   assign rd_en        = ctrl.left_read || ctrl.right_read || ctrl.check_read || ctrl.scan_read;

   // read address selection
   always_comb begin
      pat_addr   = cnt_ff[AW-1:0];
      txt_addr   = idx_ff[AW-1:0];
      left_addr  = idx_m1[AW-1:0];
      right_addr = idx_p1[AW-1:0];
      if (ctrl.right_read) begin
         pat_addr = pat_from_end[AW-1:0];
         txt_addr = idx_m1[AW-1:0];
      end
      if (ctrl.scan_read) begin
         pat_addr = ptr_ff[AW-1:0];
      end
   end

   // greedy match step, shared by both passes
   assign match  = (cnt_ff < pat_len_ff) && (pat_rd_ff == txt_rd_ff);
   assign cnt_in = cnt_ff + LW'(match);

   // window bounds for the current text position
   assign l_val  = (idx_ff == '0) ? '0 : left_rd_ff;
   assign r_val  = (idx_p1 == txt_len_ff) ? '0 : right_rd_ff;
   assign l_plus = {1'b0, l_val} + 1'b1;
   assign lim_in = (l_plus < {1'b0, pat_len_ff}) ? l_plus[LW-1:0] : pat_len_ff;

   // letter seen inside the window: last index at or below the top reaches the bottom
   assign letter_ok  = (chr_ff != '0) && (chr_ff <= CW'(csc_pkg::MAX_LETTER));
   assign reach      = (LW+1)'(last_ff[chr_ff]) + {1'b0, rcnt_ff} + 1'b1;
   assign window_hit = letter_ok && seen_ff[chr_ff] && (reach >= {1'b0, pat_len_ff});

   // memories
   always_ff @(posedge clock) begin
      if (ctrl.append_pattern && !pat_full) begin
         pat_mem[pat_len_ff[AW-1:0]] <= req_data.letter;
      end
      if (ctrl.append_text && !txt_full) begin
         txt_mem[txt_len_ff[AW-1:0]] <= req_data.letter;
      end
      if (ctrl.left_exec) begin
         left_mem[idx_ff[AW-1:0]] <= cnt_in;
      end
      if (ctrl.right_exec) begin
         right_mem[idx_m1[AW-1:0]] <= cnt_in;
      end
      // registered reads on read commands
      if (rd_en) begin
         pat_rd_ff   <= pat_mem[pat_addr];
         txt_rd_ff   <= txt_mem[txt_addr];
         left_rd_ff  <= left_mem[left_addr];
         right_rd_ff <= right_mem[right_addr];
      end
   end

   // lengths, indexes and verdict
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff <= '0;
         txt_len_ff <= '0;
         ovf_ff     <= 1'b0;
         idx_ff     <= '0;
         cnt_ff     <= '0;
         ptr_ff     <= '0;
         ok_ff      <= 1'b0;
         seen_ff    <= '0;
      end else begin
         if (ctrl.append_pattern) begin
            if (pat_full) ovf_ff <= 1'b1;
            else          pat_len_ff <= pat_len_ff + 1'b1;
         end
         if (ctrl.append_text) begin
            if (txt_full) ovf_ff <= 1'b1;
            else          txt_len_ff <= txt_len_ff + 1'b1;
         end
         if (ctrl.start_left) begin
            idx_ff <= '0;
            cnt_ff <= '0;
         end
         if (ctrl.left_exec) begin
            cnt_ff <= cnt_in;
            idx_ff <= idx_p1;
         end
         if (ctrl.start_right) begin
            idx_ff <= txt_len_ff;
            cnt_ff <= '0;
         end
         if (ctrl.right_exec) begin
            cnt_ff <= cnt_in;
            idx_ff <= idx_m1;
         end
         if (ctrl.start_check) begin
            idx_ff  <= '0;
            ptr_ff  <= '0;
            seen_ff <= '0;
            ok_ff   <= 1'b1;
         end
         if (ctrl.scan_update) begin
            ptr_ff             <= ptr_ff + 1'b1;
            seen_ff[pat_rd_ff] <= 1'b1;
         end
         if (ctrl.test) begin
            if (window_hit) idx_ff <= idx_p1;
            else            ok_ff  <= 1'b0;
         end
         if (ctrl.finish) begin
            pat_len_ff <= '0;
            txt_len_ff <= '0;
            ovf_ff     <= 1'b0;
         end
      end
   end

   // window bounds, last positions and result payload
   always_ff @(posedge clock) begin
      if (ctrl.check_limit) begin
         lim_ff  <= lim_in;
         rcnt_ff <= r_val;
         chr_ff  <= txt_rd_ff;
      end
      if (ctrl.scan_update) begin
         last_ff[pat_rd_ff] <= ptr_ff[AW-1:0];
      end
      if (ctrl.finish) begin
         rsp_ff.covered  <= ok_ff;
         rsp_ff.overflow <= ovf_ff;
      end
   end

   assign status.idx_at_len = (idx_ff == txt_len_ff);
   assign status.idx_zero   = (idx_ff == '0);
   assign status.scan_more  = (ptr_ff < lim_ff);
   assign status.window_hit = window_hit;
   assign rsp_data          = rsp_ff;

endmodule

/* hdl/csc_ctrl.sv */
module csc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_command,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  csc_pkg::status_type  status,
   output csc_pkg::ctrl_type    ctrl
);

   csc_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_take;

   assign req_stall = (state_ff != csc_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // state and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         csc_pkg::ST_IDLE: begin
            if (req_take) begin
               case (req_command)
                  csc_pkg::CMD_APPEND_PATTERN: ctrl.append_pattern = 1'b1;
                  csc_pkg::CMD_APPEND_TEXT:    ctrl.append_text = 1'b1;
                  csc_pkg::CMD_EVALUATE: begin
                     ctrl.start_left = 1'b1;
                     state_in        = csc_pkg::ST_LEFT_READ;
                  end
                  default: ;
               endcase
            end
         end
         csc_pkg::ST_LEFT_READ: begin
            if (status.idx_at_len) begin
               ctrl.start_right = 1'b1;
               state_in         = csc_pkg::ST_RIGHT_READ;
            end else begin
               ctrl.left_read = 1'b1;
               state_in       = csc_pkg::ST_LEFT_EXEC;
            end
         end
         csc_pkg::ST_LEFT_EXEC: begin
            ctrl.left_exec = 1'b1;
            state_in       = csc_pkg::ST_LEFT_READ;
         end
         csc_pkg::ST_RIGHT_READ: begin
            if (status.idx_zero) begin
               ctrl.start_check = 1'b1;
               state_in         = csc_pkg::ST_CHECK_READ;
            end else begin
               ctrl.right_read = 1'b1;
               state_in        = csc_pkg::ST_RIGHT_EXEC;
            end
         end
         csc_pkg::ST_RIGHT_EXEC: begin
            ctrl.right_exec = 1'b1;
            state_in        = csc_pkg::ST_RIGHT_READ;
         end
         csc_pkg::ST_CHECK_READ: begin
            if (status.idx_at_len) begin
               state_in = csc_pkg::ST_REPLY;
            end else begin
               ctrl.check_read = 1'b1;
               state_in        = csc_pkg::ST_CHECK_LIMIT;
            end
         end
         csc_pkg::ST_CHECK_LIMIT: begin
            ctrl.check_limit = 1'b1;
            state_in         = csc_pkg::ST_SCAN;
         end
         csc_pkg::ST_SCAN: begin
            if (status.scan_more) begin
               ctrl.scan_read = 1'b1;
               state_in       = csc_pkg::ST_SCAN_UPDATE;
            end else begin
               state_in = csc_pkg::ST_TEST;
            end
         end
         csc_pkg::ST_SCAN_UPDATE: begin
            ctrl.scan_update = 1'b1;
            state_in         = csc_pkg::ST_SCAN;
         end
         csc_pkg::ST_TEST: begin
            ctrl.test = 1'b1;
            state_in  = status.window_hit ? csc_pkg::ST_CHECK_READ : csc_pkg::ST_REPLY;
         end
         csc_pkg::ST_REPLY: begin
            // wait for the result register to be free
            if (!rsp_valid_ff || !rsp_stall) begin
               ctrl.finish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = csc_pkg::ST_IDLE;
            end
         end
         default: state_in = csc_pkg::ST_IDLE;
      endcase
   end

endmodule

/* hdl/covering_subsequence_check_unit.sv */
// Covering subsequence checker: append beats load pattern and text letters into two
// 64-entry stores, one beat per cycle while no evaluate is running, and never produce a
// result; a letter beyond a full store is dropped and sets the overflow flag. An evaluate
// beat stalls the request side and runs three passes over single-port stores with
// registered reads: a greedy left match and a greedy right match, each stepping once per
// text letter, then a window check per text letter that sweeps pattern letters into the
// per-letter last-position registers and stops at the first position that fails. When
// the evaluate returns its result, both words and the overflow flag are cleared. The
// result sits in an output register, so append beats are taken while it waits.
module covering_subsequence_check_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  csc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output csc_pkg::rsp_type  rsp_data
);

   csc_pkg::ctrl_type   ctrl;
   csc_pkg::status_type status;

   csc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .ctrl        (ctrl)
   );

   csc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctrl     (ctrl),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // a finished evaluate never overwrites a result still waiting
   assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

   // the result beat is offered right after the evaluate finishes
   assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |=> rsp_valid)
      else $error("result not presented after evaluate");

   // an accepted evaluate holds off further request beats
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.command == csc_pkg::CMD_EVALUATE)) |=> req_stall)
      else $error("request taken during evaluate");

endmodule

/* bench/covering_subsequence_check_unit_tb.sv */
module covering_subsequence_check_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LTR_W = csc_pkg::LETTER_W;
   // command code that the block ignores
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // drain time after the last result, longest evaluate of two full words
   localparam int DRAIN_CYCLES = 8 * csc_pkg::MAX_LEN + 2 * csc_pkg::MAX_LEN + 64;
   localparam int HOLD_CYCLES  = 3000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   csc_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   csc_pkg::rsp_type rsp_data;

   covering_subsequence_check_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // beats waiting to be offered and verdicts waiting to come back
   csc_pkg::req_type beat_queue [$];
   csc_pkg::rsp_type verdict_queue [$];

   int fault_count     = 0;
   int item_count      = 0;
   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   int hold_cycles     = 0;
   logic hold_trigger  = 1'b0;

   // shadow copy of the two words
   logic [LTR_W-1:0] pat_letters [csc_pkg::MAX_LEN];
   logic [LTR_W-1:0] txt_letters [csc_pkg::MAX_LEN];
   int   pat_len       = 0;
   int   txt_len       = 0;
   logic words_overflow = 1'b0;

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // greedy left and right matches, then the window test at every text position
   function automatic logic cover_verdict();
      int   fwd [csc_pkg::MAX_LEN];
      int   bwd [csc_pkg::MAX_LEN];
      int   k;
      int   lo;
      int   hi;
      logic hit;
      k = 0;
      for (int i = 0; i < txt_len; i++) begin
         if (k < pat_len && pat_letters[k] == txt_letters[i]) k++;
         fwd[i] = k;
      end
      k = 0;
      for (int i = txt_len - 1; i >= 0; i--) begin
         if (k < pat_len && pat_letters[pat_len - 1 - k] == txt_letters[i]) k++;
         bwd[i] = k;
      end
      for (int i = 0; i < txt_len; i++) begin
         hi = (i == 0) ? 0 : fwd[i - 1];
         lo = pat_len - ((i == txt_len - 1) ? 0 : bwd[i + 1]) - 1;
         if (lo < 0) lo = 0;
         if (hi > pat_len - 1) hi = pat_len - 1;
         hit = 1'b0;
         // out-of-range codes never pass
         if (txt_letters[i] >= 1 && txt_letters[i] <= csc_pkg::MAX_LETTER) begin
            for (int j = lo; j <= hi; j++) begin
               if (pat_letters[j] == txt_letters[i]) hit = 1'b1;
            end
         end
         if (!hit) return 1'b0;
      end
      return 1'b1;
   endfunction

   // update the shadow words with one accepted beat
   function automatic void absorb_beat(csc_pkg::req_type b);
      csc_pkg::rsp_type verdict;
      case (b.command)
         csc_pkg::CMD_APPEND_PATTERN: begin
            if (pat_len < csc_pkg::MAX_LEN) begin
               pat_letters[pat_len] = b.letter;
               pat_len++;
            end else begin
               words_overflow = 1'b1;
            end
         end
         csc_pkg::CMD_APPEND_TEXT: begin
            if (txt_len < csc_pkg::MAX_LEN) begin
               txt_letters[txt_len] = b.letter;
               txt_len++;
            end else begin
               words_overflow = 1'b1;
            end
         end
         csc_pkg::CMD_EVALUATE: begin
            verdict.covered  = cover_verdict();
            verdict.overflow = words_overflow;
            verdict_queue    = {verdict_queue, verdict};
            pat_len        = 0;
            txt_len        = 0;
            words_overflow = 1'b0;
         end
         default: begin
         end
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) absorb_beat(req_data);
         if (!req_valid || !req_stall) begin
            if (beat_queue.size() != 0 &&
                (hold_cycles != 0 || $urandom_range(99) >= sender_idle_pct)) begin
               req_data  <= beat_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin : rsp_check
      csc_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t: unexpected result covered %0b overflow %0b",
                        $time, rsp_data.covered, rsp_data.overflow);
               fault_count++;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_data.covered !== want.covered) begin
                  $display("%0t: covered expected %0b actual %0b",
                           $time, want.covered, rsp_data.covered);
                  fault_count++;
               end
               if (rsp_data.overflow !== want.overflow) begin
                  $display("%0t: overflow expected %0b actual %0b",
                           $time, want.overflow, rsp_data.overflow);
                  fault_count++;
               end
            end
         end
         rsp_stall <= (hold_cycles != 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
      else if (hold_trigger) hold_cycles <= HOLD_CYCLES;
   end

   function automatic void queue_beat(logic [1:0] cmd, logic [LTR_W-1:0] ltr);
      csc_pkg::req_type b;
      b.command  = cmd;
      b.letter   = ltr;
      beat_queue = {beat_queue, b};
      if (cmd != CMD_UNUSED) item_count++;
   endfunction

   // mostly in-alphabet letters, now and then any code at all
   function automatic logic [LTR_W-1:0] pick_letter(int alpha);
      if ($urandom_range(19) == 0) return LTR_W'($urandom_range(0, 7));
      return LTR_W'($urandom_range(1, alpha));
   endfunction

   function automatic int pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(0, 8);
      if (r < 97) return $urandom_range(9, 40);
      return $urandom_range(60, 70);
   endfunction

   // one pattern and text pair, appends in some order, then evaluate
   function automatic void queue_pair(int n_pat, int n_txt, bit stretch);
      logic [LTR_W-1:0] pat [$];
      logic [LTR_W-1:0] txt [$];
      int alpha;
      int pi;
      int ti;
      bit mix;
      bit pat_first;
      alpha = ($urandom_range(3) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
      for (int i = 0; i < n_pat; i++) pat = {pat, pick_letter(alpha)};
      if (stretch) begin
         // text built by repeating pattern letters, sometimes with a stray letter
         foreach (pat[i]) begin
            for (int r = $urandom_range(1, 3); r > 0; r--) txt = {txt, pat[i]};
            if ($urandom_range(9) == 0) txt = {txt, pick_letter(alpha)};
         end
      end else begin
         for (int i = 0; i < n_txt; i++) txt = {txt, pick_letter(alpha)};
      end
      mix       = $urandom_range(1);
      pat_first = $urandom_range(1);
      pi = 0;
      ti = 0;
      while (pi < pat.size() || ti < txt.size()) begin
         if ($urandom_range(29) == 0) queue_beat(CMD_UNUSED, LTR_W'($urandom_range(7)));
         if (ti >= txt.size() ||
             (pi < pat.size() && (mix ? $urandom_range(1) == 1 : pat_first))) begin
            queue_beat(csc_pkg::CMD_APPEND_PATTERN, pat[pi]);
            pi++;
         end else begin
            queue_beat(csc_pkg::CMD_APPEND_TEXT, txt[ti]);
            ti++;
         end
      end
      queue_beat(csc_pkg::CMD_EVALUATE, LTR_W'($urandom_range(7)));
   endfunction

   task automatic run_phase(int idle_pct, int stall_pct, int target);
      sender_idle_pct = idle_pct;
      recv_stall_pct  = stall_pct;
      while (item_count < target) begin
         if ($urandom_range(2) == 0) queue_pair(pick_size(), 0, 1'b1);
         else queue_pair(pick_size(), pick_size(), 1'b0);
      end
      while (beat_queue.size() != 0) @(posedge clock);
   endtask

   // stimulus sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty text
      queue_beat(csc_pkg::CMD_EVALUATE, 3'd7);
      // single top letter on both sides
      queue_beat(csc_pkg::CMD_APPEND_PATTERN, 3'd7);
      queue_beat(csc_pkg::CMD_APPEND_TEXT, 3'd7);
      queue_beat(csc_pkg::CMD_EVALUATE, 3'd0);
      // empty pattern with a text
      queue_beat(csc_pkg::CMD_APPEND_TEXT, 3'd3);
      queue_beat(csc_pkg::CMD_EVALUATE, 3'd5);
      // stretched pattern
      queue_beat(csc_pkg::CMD_APPEND_PATTERN, 3'd1);
      queue_beat(csc_pkg::CMD_APPEND_PATTERN, 3'd2);
      queue_beat(csc_pkg::CMD_APPEND_TEXT, 3'd1);
      queue_beat(csc_pkg::CMD_APPEND_TEXT, 3'd1);
      queue_beat(csc_pkg::CMD_APPEND_TEXT, 3'd2);
      queue_beat(csc_pkg::CMD_APPEND_TEXT, 3'd2);
      queue_beat(csc_pkg::CMD_EVALUATE, 3'd2);
      // trailing letter left uncovered
      queue_beat(csc_pkg::CMD_APPEND_PATTERN, 3'd1);
      queue_beat(csc_pkg::CMD_APPEND_PATTERN, 3'd2);
      queue_beat(csc_pkg::CMD_APPEND_TEXT, 3'd1);
      queue_beat(csc_pkg::CMD_APPEND_TEXT, 3'd2);
      queue_beat(csc_pkg::CMD_APPEND_TEXT, 3'd1);
      queue_beat(csc_pkg::CMD_EVALUATE, 3'd4);
      // out-of-range letter code in both words
      queue_beat(csc_pkg::CMD_APPEND_PATTERN, 3'd0);
      queue_beat(csc_pkg::CMD_APPEND_TEXT, 3'd0);
      // ignored command between appends and evaluate
      queue_beat(CMD_UNUSED, 3'd6);
      queue_beat(csc_pkg::CMD_EVALUATE, 3'd1);

      run_phase(0, 0, 450);
      run_phase(79, 0, 850);
      run_phase(0, 79, 1250);
      run_phase(15, 15, 1650);

      // receiver holds off while the sender keeps offering beats
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      @(posedge clock);
      hold_trigger <= 1'b1;
      @(posedge clock);
      hold_trigger <= 1'b0;
      while (item_count < 1700) queue_pair($urandom_range(0, 4), $urandom_range(0, 4), 1'b0);
      while (beat_queue.size() != 0) @(posedge clock);

      // drain
      while (req_valid || verdict_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (verdict_queue.size() != 0) fault_count++;

      if (fault_count == 0) begin
         $display("covering_subsequence_check_unit_tb passed");
      end else begin
         $display("covering_subsequence_check_unit_tb failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("covering_subsequence_check_unit_tb failed");
      $finish;
   end

endmodule

/* covering_subsequence_check_unit.f */
hdl/csc_pkg.sv
hdl/csc_datapath.sv
hdl/csc_ctrl.sv
hdl/covering_subsequence_check_unit.sv
bench/covering_subsequence_check_unit_tb.sv
